// File: hw/rtl/zcars_pkg.sv
package zcars_pkg;

	localparam int unsigned ScaleW = 16;
	localparam int unsigned WaveW  = 8;

	localparam logic [ScaleW-1:0] SlewUpReset   = 16'd655;
	localparam logic [ScaleW-1:0] SlewDownReset = 16'd655;
	localparam logic [ScaleW-1:0] MinStepReset  = 16'd1;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_DOWN   = 3'd1,
		PH_SWITCH = 3'd2,
		PH_UP     = 3'd3,
		PH_HOLD   = 3'd4,
		PH_FAULT  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		REQ_SET_TARGET = 2'd0,
		REQ_ZERO_CROSS = 2'd1,
		REQ_TRIP       = 2'd2,
		REQ_INIT       = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		CFG_SLEW_UP   = 2'd0,
		CFG_SLEW_DOWN = 2'd1,
		CFG_MIN_STEP  = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [ScaleW-1:0] slew_up;
		logic [ScaleW-1:0] slew_down;
		logic [ScaleW-1:0] floor_step;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		logic [ScaleW-1:0] present_scale;
		logic [ScaleW-1:0] goal_scale;
		logic [WaveW-1:0]  present_wave;
		logic [WaveW-1:0]  goal_wave;
		logic              switch_pending;
	} seq_state_t;

	typedef struct packed {
		logic [ScaleW-1:0] scale_out;
		logic              scale_applied;
		logic [WaveW-1:0]  waveform_out;
		phase_t            phase_code;
	} result_t;

	function automatic logic [ScaleW-1:0] max_step(input logic [ScaleW-1:0] a,
		input logic [ScaleW-1:0] b);
		return (a > b) ? a : b;
	endfunction

	// one ramp step toward goal, never overshooting it
	function automatic logic [ScaleW-1:0] approach(input logic [ScaleW-1:0] now,
		input logic [ScaleW-1:0] goal, input logic [ScaleW-1:0] step);
		logic [ScaleW:0]   sum;
		logic [ScaleW-1:0] diff;
		sum  = {1'b0, now} + {1'b0, step};
		diff = now - goal;
		if (goal > now) begin
			return (sum > {1'b0, goal}) ? goal : sum[ScaleW-1:0];
		end else if (goal < now) begin
			return (diff < step) ? goal : now - step;
		end else begin
			return now;
		end
	endfunction

endpackage

// File: hw/rtl/zcars_cfg_regs.sv
module zcars_cfg_regs
	import zcars_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [1:0]        wr_index,
	input  logic [ScaleW-1:0] wr_data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slew_up    <= SlewUpReset;
			cfg_q.slew_down  <= SlewDownReset;
			cfg_q.floor_step <= MinStepReset;
		end else if (wr_en) begin
			case (cfg_idx_t'(wr_index))
				CFG_SLEW_UP:   cfg_q.slew_up    <= wr_data;
				CFG_SLEW_DOWN: cfg_q.slew_down  <= wr_data;
				CFG_MIN_STEP:  cfg_q.floor_step <= wr_data;
				default: ; // unmapped index, ignored
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/zcars_step_logic.sv
module zcars_step_logic
	import zcars_pkg::*;
(
	input  seq_state_t        cur,
	input  cfg_t              cfg,
	input  req_t              req,
	input  logic [ScaleW-1:0] tgt_scale,
	input  logic [WaveW-1:0]  tgt_wave,
	output seq_state_t        nxt,
	output result_t           res
);

	logic [ScaleW-1:0] up_step;
	logic [ScaleW-1:0] down_step;
	logic [ScaleW-1:0] down_scale;
	logic [ScaleW-1:0] up_scale;
	logic              pend;
	logic              applied;

	assign up_step    = max_step(cfg.slew_up, cfg.floor_step);
	assign down_step  = max_step(cfg.slew_down, cfg.floor_step);
	assign down_scale = approach(cur.present_scale, '0, down_step);
	assign up_scale   = approach(cur.present_scale, cur.goal_scale, up_step);
	assign pend       = (tgt_wave != cur.present_wave);

	always_comb begin
		nxt     = cur;
		applied = 1'b0;
		case (req)
			REQ_SET_TARGET: begin
				nxt.goal_scale     = tgt_scale;
				nxt.goal_wave      = tgt_wave;
				nxt.switch_pending = pend;
				if (cur.phase inside {PH_IDLE, PH_HOLD}) begin
					nxt.phase = pend ? PH_DOWN : PH_UP;
				end
			end
			REQ_ZERO_CROSS: begin
				case (cur.phase)
					PH_DOWN: begin
						nxt.present_scale = down_scale;
						applied           = 1'b1;
						if (down_scale == '0) begin
							nxt.phase = cur.switch_pending ? PH_SWITCH : PH_UP;
						end
					end
					PH_SWITCH: begin
						nxt.present_wave   = cur.goal_wave;
						nxt.switch_pending = 1'b0;
						nxt.phase          = PH_UP;
						applied            = 1'b1;
					end
					PH_UP: begin
						nxt.present_scale = up_scale;
						applied           = 1'b1;
						if (up_scale == cur.goal_scale) begin
							nxt.phase = PH_HOLD;
						end
					end
					PH_FAULT: applied = 1'b1;
					default: ; // idle/hold: tick does nothing
				endcase
			end
			REQ_TRIP: nxt.phase = PH_FAULT;
			REQ_INIT: nxt = '0;
			default: nxt = cur;
		endcase
	end

	always_comb begin
		res.scale_out     = (nxt.phase == PH_FAULT) ? '0 : nxt.present_scale;
		res.scale_applied = applied;
		res.waveform_out  = nxt.present_wave;
		res.phase_code    = nxt.phase;
	end

endmodule

// File: hw/rtl/zero_cross_amplitude_ramp_sequencer_unit.sv
// Amplitude ramp sequencer for a signal generator output. Each input item is
// a request (set target, zero-cross tick, protection trip, init) and yields
// exactly one result item carrying the output scale, an applied flag, the
// waveform in effect and the phase after the request. Throughput is one item
// per clock while the result stream is not stalled. The item lands in an
// input register; the state update and result are computed from it in one
// pass and captured together in the state and result registers. A stalled
// result does not stop intake: the input register holds one more item until
// the result register frees up.
// Ramp steps are max(slew, minimum_step), clamped at the goal. A trip holds
// the scale output at zero until init. Config writes take effect at once and
// are meant to be issued only while no request is in flight.
module zero_cross_amplitude_ramp_sequencer_unit
	import zcars_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [15:0] target_scale, [23:16] target_waveform
	input  logic [1:0]  s_tuser,   // [1:0] req_type
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [15:0] scale_out, [16] scale_applied,
	                               // [24:17] waveform_out, [27:25] phase_code, rest zero
	// config write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	cfg_t              cfg;
	seq_state_t        state_q;
	seq_state_t        state_nxt;
	result_t           res;
	result_t           res_q;
	logic              out_valid_q;

	// input stage
	logic              valid_s1;
	req_t              req_s1;
	logic [ScaleW-1:0] tscale_s1;
	logic [WaveW-1:0]  twave_s1;
	logic              adv_s1;

	assign cfg_ready = 1'b1;

	zcars_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// input item moves on when the result slot is empty or being drained
	assign adv_s1   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1    <= req_t'(s_tuser);
			tscale_s1 <= s_tdata[15:0];
			twave_s1  <= s_tdata[23:16];
		end
	end

	zcars_step_logic u_step (
		.cur       (state_q),
		.cfg       (cfg),
		.req       (req_s1),
		.tgt_scale (tscale_s1),
		.tgt_wave  (twave_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	// sequencer state commits together with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			state_q     <= state_nxt;
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'b0, res_q.phase_code, res_q.waveform_out,
	                   res_q.scale_applied, res_q.scale_out};

`ifndef NO_ASSERTIONS
	// a held input item is not dropped while the result slot is blocked
	a_s1_kept: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |=> valid_s1)
		else $error("input item lost while stalled");

	// the waveform only switches at zero scale
	a_switch_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.phase == PH_SWITCH |-> state_q.present_scale == '0)
		else $error("switch phase with nonzero scale");

	// an applied result never reports the idle phase
	a_applied_not_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.scale_applied |-> res_q.phase_code != PH_IDLE)
		else $error("applied flag with idle phase");
`endif

endmodule
